>>> rtl/core/sobel_edge_magnitude_rgb_macros.svh
// Assertion macros used by the checker file of the Sobel edge block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// Property that must hold at every edge outside reset.
`define SEM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in one cycle that implies a consequence in the next one.
`define SEM_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sem_pkg.sv
// Shared types, constants and gradient helpers of the Sobel edge block.
// No dependencies; every RTL module refers to it by scoped names.
package sem_pkg;

    localparam int unsigned CFG_W       = 11;     // width of each config register
    localparam int unsigned CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_HEIGHT    = 1024;
    localparam int unsigned ROW_W         = 10;    // holds 0 .. MAX_HEIGHT-1
    localparam int unsigned MIN_DIM       = 3;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned WIN_N  = 9;
    localparam int unsigned GRAD_W = 10;           // |gx|, |gy| up to 1020
    localparam int unsigned SUM_W  = 21;           // gx^2 + gy^2 up to 2080800

    // rounded root above 255 once the sum passes 255*255 + 255
    localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(65280);
    localparam logic [CH_W-1:0]  CH_MAX  = 8'hFF;

    localparam int unsigned ROOT_STEPS      = CH_W;
    localparam int unsigned ROOT_IN_W       = 2 * ROOT_STEPS;
    localparam int unsigned ROOT_W          = ROOT_IN_W + 1;
    localparam int unsigned STEPS_PER_STAGE = 2;
    localparam int unsigned ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;
    localparam int unsigned ROOT_LAT        = ROOT_STAGES + 1;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    // index is row * 3 + column, row 0 the oldest line
    typedef t_pix [WIN_N-1:0] t_win;

    typedef struct packed {
        t_win win;
        logic done;
    } t_item;

    function automatic logic [CH_W-1:0] pix_chan(input t_pix p, input t_chan ch);
        logic [CH_W-1:0] v;
        case (ch)
            CH_RED:   v = p.red;
            CH_GREEN: v = p.green;
            CH_BLUE:  v = p.blue;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [GRAD_W-1:0] tri_sum(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b,
                                                  input logic [CH_W-1:0] c);
        return GRAD_W'(a) + (GRAD_W'(b) << 1) + GRAD_W'(c);
    endfunction

    function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] p,
                                                   input logic [GRAD_W-1:0] n);
        return (p >= n) ? (p - n) : (n - p);
    endfunction

    // |Gx|: right column against left column
    function automatic logic [GRAD_W-1:0] grad_x(input t_win w, input t_chan ch);
        logic [GRAD_W-1:0] p, n;
        p = tri_sum(pix_chan(w[2], ch), pix_chan(w[5], ch), pix_chan(w[8], ch));
        n = tri_sum(pix_chan(w[0], ch), pix_chan(w[3], ch), pix_chan(w[6], ch));
        return abs_diff(p, n);
    endfunction

    // |Gy|: bottom row against top row
    function automatic logic [GRAD_W-1:0] grad_y(input t_win w, input t_chan ch);
        logic [GRAD_W-1:0] p, n;
        p = tri_sum(pix_chan(w[6], ch), pix_chan(w[7], ch), pix_chan(w[8], ch));
        n = tri_sum(pix_chan(w[0], ch), pix_chan(w[1], ch), pix_chan(w[2], ch));
        return abs_diff(p, n);
    endfunction

endpackage

>>> rtl/core/sem_front.sv
// Front end: config registers, raster counters, line stores and 3x3 window.
// Uses sem_pkg; pushes complete windows of interior pixels to the queue.
module sem_front #(
    parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sem_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  sem_pkg::t_pix                 i_pix,
    output logic                          o_in_stall,
    output logic                          o_push,
    output sem_pkg::t_item                o_item,
    input  logic                          i_q_full
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned DW = ($clog2(MAX_WIDTH + 1) > sem_pkg::CFG_W) ?
                                 $clog2(MAX_WIDTH + 1) : sem_pkg::CFG_W;

    logic [sem_pkg::CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]             r_col, n_col;
    logic [sem_pkg::ROW_W-1:0] r_row, n_row;

    logic [DW-1:0]             w_eff, col_x;
    logic [sem_pkg::CFG_W-1:0] h_eff, row_x;
    logic                      acc, leave, last_col, has_res, is_done;

    logic [23:0] mem_prior [MAX_WIDTH];
    logic [23:0] mem_older [MAX_WIDTH];
    sem_pkg::t_pix r_prior_rd, r_older_rd;

    logic                r_a_vld, r_a_has, r_a_done;
    logic [CW-1:0]       r_a_col;
    sem_pkg::t_pix       r_a_px;
    sem_pkg::t_win       r_win, n_win;

    // clamp the dimensions to their legal ranges
    always_comb begin
        if (r_width < sem_pkg::CFG_W'(sem_pkg::MIN_DIM)) begin
            w_eff = DW'(sem_pkg::MIN_DIM);
        end else if (DW'(r_width) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(r_width);
        end
        if (r_height < sem_pkg::CFG_W'(sem_pkg::MIN_DIM)) begin
            h_eff = sem_pkg::CFG_W'(sem_pkg::MIN_DIM);
        end else if (r_height > sem_pkg::CFG_W'(sem_pkg::MAX_HEIGHT)) begin
            h_eff = sem_pkg::CFG_W'(sem_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign col_x    = DW'(r_col);
    assign row_x    = sem_pkg::CFG_W'(r_row);
    assign last_col = (col_x + DW'(1)) >= w_eff;
    assign has_res  = (r_row >= sem_pkg::ROW_W'(2)) && (r_col >= CW'(2));
    assign is_done  = (row_x == h_eff - sem_pkg::CFG_W'(1)) && (col_x == w_eff - DW'(1));

    assign leave      = r_a_vld && !(r_a_has && i_q_full);
    assign o_in_stall = r_a_vld && !leave;
    assign acc        = i_in_valid && !o_in_stall;

    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = ((row_x + sem_pkg::CFG_W'(1)) >= h_eff) ? '0 : r_row + sem_pkg::ROW_W'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::CFG_W'(sem_pkg::MIN_DIM);
            r_height <= sem_pkg::CFG_W'(sem_pkg::MIN_DIM);
            r_col    <= '0;
            r_row    <= '0;
            r_a_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sem_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                    sem_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
                // any write restarts the frame
                r_col <= '0;
                r_row <= '0;
            end else if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (acc) begin
                r_a_vld <= 1'b1;
            end else if (leave) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    // classify at accept, read both line stores at the pixel's column
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_has    <= has_res;
            r_a_done   <= is_done;
            r_a_col    <= r_col;
            r_a_px     <= i_pix;
            r_prior_rd <= mem_prior[r_col];
            r_older_rd <= mem_older[r_col];
        end
    end

    // write back when the pixel leaves the accept register; the next read of this column is a row away
    always_ff @(posedge i_clk) begin
        if (leave) begin
            mem_older[r_a_col] <= r_prior_rd;
            mem_prior[r_a_col] <= r_a_px;
        end
    end

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_older_rd;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_prior_rd;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (leave) begin
            r_win <= n_win;
        end
    end

    assign o_push      = leave && r_a_has;
    assign o_item.win  = n_win;
    assign o_item.done = r_a_done;

endmodule

>>> rtl/core/sem_queue.sv
// Short FIFO of complete windows between the front and back ends.
// Uses sem_pkg for the item type and depth.
module sem_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sem_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_vld,
    output sem_pkg::t_item o_item,
    input  logic           i_pop
);

    sem_pkg::t_item             r_mem [sem_pkg::Q_DEPTH];
    logic [sem_pkg::Q_AW-1:0]   r_wp, r_rp;
    logic [sem_pkg::Q_AW:0]     r_cnt;
    logic                       do_push, do_pop;

    function automatic logic [sem_pkg::Q_AW-1:0] bump(input logic [sem_pkg::Q_AW-1:0] p);
        return (p == sem_pkg::Q_AW'(sem_pkg::Q_DEPTH - 1)) ? '0 : p + sem_pkg::Q_AW'(1);
    endfunction

    assign o_full  = r_cnt == (sem_pkg::Q_AW + 1)'(sem_pkg::Q_DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= bump(r_wp);
            end
            if (do_pop) begin
                r_rp <= bump(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (sem_pkg::Q_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (sem_pkg::Q_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

>>> rtl/core/sem_root.sv
// Pipelined integer square root, two result bits per stage, with a range flag.
// Uses sem_pkg; returns floor root and remainder for rounding downstream.
module sem_root (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [sem_pkg::SUM_W-1:0]  i_sum,
    output logic                       o_sat,
    output logic [sem_pkg::ROOT_STEPS-1:0] o_res,
    output logic [sem_pkg::ROOT_STEPS:0]   o_rem
);

    localparam int unsigned RW = sem_pkg::ROOT_W;
    localparam int unsigned NS = sem_pkg::ROOT_STAGES;

    logic [RW-1:0] r_rem [NS+1];
    logic [RW-1:0] r_res [NS+1];
    logic          r_sat [NS+1];

    // one digit: try subtracting res + bit, shift the partial root
    function automatic logic [2*RW-1:0] root_step(input logic [RW-1:0] rem,
                                                  input logic [RW-1:0] res,
                                                  input int unsigned   i);
        logic [RW-1:0] b, t, nrem, nres;
        b = RW'(1) << (2 * (sem_pkg::ROOT_STEPS - 1 - i));
        t = res + b;
        if (rem >= t) begin
            nrem = rem - t;
            nres = (res >> 1) + b;
        end else begin
            nrem = rem;
            nres = res >> 1;
        end
        return {nrem, nres};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= i_sum > sem_pkg::SAT_LIM;
            r_rem[0] <= RW'(i_sum[sem_pkg::ROOT_IN_W-1:0]);
            r_res[0] <= '0;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [RW-1:0] c_rem, c_res;

        always_comb begin
            c_rem = r_rem[g];
            c_res = r_res[g];
            for (int unsigned k = 0; k < sem_pkg::STEPS_PER_STAGE; k++) begin
                {c_rem, c_res} = root_step(c_rem, c_res, g * sem_pkg::STEPS_PER_STAGE + k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= c_rem;
                r_res[g+1] <= c_res;
                r_sat[g+1] <= r_sat[g];
            end
        end
    end

    assign o_sat = r_sat[NS];
    assign o_res = r_res[NS][sem_pkg::ROOT_STEPS-1:0];
    assign o_rem = r_rem[NS][sem_pkg::ROOT_STEPS:0];

endmodule

>>> rtl/core/sem_back.sv
// Back end: gradients, squared magnitude, rounded root and output register.
// Uses sem_pkg and sem_root; the whole pipe holds while the output stalls.
module sem_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_vld,
    input  sem_pkg::t_item i_q_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sem_pkg::t_pix  o_edge,
    output logic           o_done
);

    localparam int unsigned NC = 3;
    localparam int unsigned GW = sem_pkg::GRAD_W;
    localparam int unsigned LT = sem_pkg::ROOT_LAT;

    logic en;

    logic                        r1_vld, r1_done;
    logic [GW-1:0]               r1_ax [NC];
    logic [GW-1:0]               r1_ay [NC];
    logic                        r2_vld, r2_done;
    logic [sem_pkg::SUM_W-1:0]   r2_sum [NC];
    logic [LT-1:0]               r_vpipe, r_dpipe;

    logic                             rt_sat [NC];
    logic [sem_pkg::ROOT_STEPS-1:0]   rt_res [NC];
    logic [sem_pkg::ROOT_STEPS:0]     rt_rem [NC];
    logic [sem_pkg::CH_W-1:0]         rnd    [NC];

    logic                       r_out_vld, r_out_done;
    logic [sem_pkg::CH_W-1:0]   r_out [NC];

    assign en    = !(r_out_vld && i_out_stall);
    assign o_pop = en && i_q_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_vpipe   <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_q_vld;
            r2_vld    <= r1_vld;
            r_vpipe   <= {r_vpipe[LT-2:0], r2_vld};
            r_out_vld <= r_vpipe[LT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_done    <= i_q_item.done;
            r2_done    <= r1_done;
            r_dpipe    <= {r_dpipe[LT-2:0], r2_done};
            r_out_done <= r_dpipe[LT-1];
        end
    end

    for (genvar c = 0; c < NC; c++) begin : g_chan
        logic [2*GW-1:0] sqx, sqy;

        assign sqx = (2*GW)'(r1_ax[c]) * (2*GW)'(r1_ax[c]);
        assign sqy = (2*GW)'(r1_ay[c]) * (2*GW)'(r1_ay[c]);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_ax[c]  <= sem_pkg::grad_x(i_q_item.win, sem_pkg::t_chan'(c));
                r1_ay[c]  <= sem_pkg::grad_y(i_q_item.win, sem_pkg::t_chan'(c));
                r2_sum[c] <= sem_pkg::SUM_W'(sqx) + sem_pkg::SUM_W'(sqy);
            end
        end

        sem_root u_root (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sum (r2_sum[c]),
            .o_sat (rt_sat[c]),
            .o_res (rt_res[c]),
            .o_rem (rt_rem[c])
        );

        // round up when the remainder passes the floor root
        assign rnd[c] = rt_sat[c] ? sem_pkg::CH_MAX :
                        rt_res[c] + sem_pkg::CH_W'(rt_rem[c] > (sem_pkg::ROOT_STEPS + 1)'(rt_res[c]));

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_out[c] <= rnd[c];
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_done       = r_out_done;
    assign o_edge.red   = r_out[sem_pkg::CH_RED];
    assign o_edge.green = r_out[sem_pkg::CH_GREEN];
    assign o_edge.blue  = r_out[sem_pkg::CH_BLUE];

endmodule

>>> rtl/core/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block.
// Uses sem_pkg, sem_front, sem_queue and sem_back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   pixel in | i_in_valid / o_in_stall    | i_red_in, i_green_in, i_blue_in
//   edge out | o_out_valid / i_out_stall  | o_red_edge, o_green_edge, o_blue_edge,
//            |                            | o_frame_done
//   config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Takes one pixel per clock while the output side keeps up; the line stores
// are read at accept and written back when the pixel leaves the front stage,
// each through one read and one write port. With no stalls, o_out_valid
// rises once the pixel that completes its window has passed one front stage,
// the queue, gradient, square, five root stages (a range check, then two root
// bits in each of four) and the output register.
// Synchronous active-low reset clears counters, valids and sets both
// dimensions to 3; the line stores and window are not cleared.
// An output stall freezes the back pipe; the four-entry queue then fills and
// the front raises o_in_stall only when it holds a result it cannot push.
module sobel_edge_magnitude_rgb #(
    parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sem_pkg::CFG_W-1:0]     i_cfg_data,
    // pixel stream in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sem_pkg::CH_W-1:0]      i_red_in,
    input  logic [sem_pkg::CH_W-1:0]      i_green_in,
    input  logic [sem_pkg::CH_W-1:0]      i_blue_in,
    // edge magnitudes out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sem_pkg::CH_W-1:0]      o_red_edge,
    output logic [sem_pkg::CH_W-1:0]      o_green_edge,
    output logic [sem_pkg::CH_W-1:0]      o_blue_edge,
    output logic                          o_frame_done
);

    sem_pkg::t_pix  in_pix, out_edge;
    sem_pkg::t_item push_item, head_item;
    logic           push, q_full, q_vld, pop;

    assign in_pix.red   = i_red_in;
    assign in_pix.green = i_green_in;
    assign in_pix.blue  = i_blue_in;

    // front: classify pixels, keep line stores and window
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_pix      (in_pix),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (push_item),
        .i_q_full   (q_full)
    );

    // decouple: hold a few windows while the back end stalls
    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (head_item),
        .i_pop   (pop)
    );

    // back: gradients, magnitude and rounded root per channel
    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_item    (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_edge      (out_edge),
        .o_done      (o_frame_done)
    );

    assign o_red_edge   = out_edge.red;
    assign o_green_edge = out_edge.green;
    assign o_blue_edge  = out_edge.blue;

endmodule

>>> rtl/core/sem_check.sv
// Port-level checker for the Sobel edge block, bound to the top level.
// Uses sem_pkg widths and the assertion macros header.
`include "sobel_edge_magnitude_rgb_macros.svh"

module sem_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sem_pkg::CH_W-1:0]      o_red_edge,
    input logic [sem_pkg::CH_W-1:0]      o_green_edge,
    input logic [sem_pkg::CH_W-1:0]      o_blue_edge,
    input logic                          o_frame_done
);

    // a full window needs at least two rows of three plus three pixels
    localparam logic [3:0] MIN_PIX = 4'd9;

    logic [3:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cfg_we) begin
            r_cnt <= '0;
        end else if (i_in_valid && !o_in_stall && r_cnt != MIN_PIX) begin
            r_cnt <= r_cnt + 4'd1;
        end
    end

    `SEM_CHECK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_red_edge) && $stable(o_green_edge) && $stable(o_blue_edge) && $stable(o_frame_done), "stalled result changed")
    `SEM_CHECK(a_out_needs_window, o_out_valid |-> r_cnt == MIN_PIX, "result before a full window")
    `SEM_CHECK(a_stall_needs_window, o_in_stall |-> r_cnt == MIN_PIX, "input stalled with no results")

endmodule

bind sobel_edge_magnitude_rgb sem_check u_sem_check (.*);
